// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int DELAY_BITS = 8;
    localparam int DELAY_MAX  = (1 << DELAY_BITS) - 1;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_WAIT_ACK = 3'd5;

    localparam logic [1:0] REG_START_STOP_DELAY = 2'd0;
    localparam logic [1:0] REG_BIT_DELAY        = 2'd1;
    localparam logic [1:0] REG_SAMPLE_DELAY     = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT      = 2'd3;

    typedef enum logic [1:0] {
        K_TICK,
        K_CMD,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] op;
        logic [7:0] data;
        logic       ack;
        logic       sda;
    } item_t;

    typedef struct packed {
        logic [7:0] start_stop_delay;
        logic [7:0] bit_delay;
        logic [7:0] sample_delay;
        logic [7:0] ack_timeout;
    } cfg_t;

endpackage

// File: sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: queued command and tick requests drive SCL/SDA.
//
//   channel   handshake              payload
//   input     push / full            opcode, data_byte, send_ack, sda_in
//   result    empty / pop            scl_level .. ack_failed (one per request)
//   config    psel/penable/pwrite    paddr[3:2] register, pwdata[7:0]
//
// One request per clock cycle, sustained while results are popped; a result
// reaches the result ports once its request has passed the front queue and
// the engine step into the result queue, where it can then be popped.
// The engine steps once per request it takes and stalls on a full result queue.
// Reset loads the default delays and leaves SCL and SDA driven high.
// With pop held low, two results and two requests are buffered, then full rises.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_failed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    i2cm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .data_byte (data_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2cm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .rx_byte    (rx_byte),
        .ack_failed (ack_failed)
    );

endmodule

// File: sv/i2cm_regs.sv
// ----------------------------------------------------------------------------
// i2cm_regs
// APB-style register file holding the delay and timeout settings.
// ----------------------------------------------------------------------------
module i2cm_regs
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_stop_delay <= 8'd4;
            cfg_reg.bit_delay        <= 8'd2;
            cfg_reg.sample_delay     <= 8'd1;
            cfg_reg.ack_timeout      <= 8'd250;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_STOP_DELAY: cfg_reg.start_stop_delay <= pwdata[7:0];
                REG_BIT_DELAY:        cfg_reg.bit_delay        <= pwdata[7:0];
                REG_SAMPLE_DELAY:     cfg_reg.sample_delay     <= pwdata[7:0];
                default:              cfg_reg.ack_timeout      <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_STOP_DELAY: prdata = {24'd0, cfg_reg.start_stop_delay};
            REG_BIT_DELAY:        prdata = {24'd0, cfg_reg.bit_delay};
            REG_SAMPLE_DELAY:     prdata = {24'd0, cfg_reg.sample_delay};
            default:              prdata = {24'd0, cfg_reg.ack_timeout};
        endcase
    end

endmodule

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests, classifies the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] opcode,
    input  logic [7:0] data_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    item_t      new_item;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push & ~full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb
    begin
        new_item.op   = opcode;
        new_item.data = data_byte;
        new_item.ack  = send_ack;
        new_item.sda  = sda_in;
        if (opcode == OP_TICK)
            new_item.kind = K_TICK;
        else if (opcode inside {[OP_START:OP_WAIT_ACK]})
            new_item.kind = K_CMD;
        else
            new_item.kind = K_NOP;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({do_push, q_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("front queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0)
        else $error("front queue popped while empty");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !q_pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("front queue lost a request");

endmodule

// File: sv/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bit-level state machine that carries out queued requests and buffers the
// results in a two-entry output queue.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_failed
);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_WR_TAIL,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_WA_LOW,
        PH_WA_HIGH,
        PH_WA_POLL
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } res_t;

    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [7:0] d);
        logic [DELAY_BITS+7:0] w;
        w = (DELAY_BITS + 8)'(d);
        if (w > (DELAY_BITS + 8)'(DELAY_MAX))
            w = (DELAY_BITS + 8)'(DELAY_MAX);
        return w[DELAY_BITS-1:0];
    endfunction

    phase_t                phase_reg, phase_next;
    logic [3:0]            bits_reg, bits_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            poll_reg, poll_next;
    logic                  ackc_reg, ackc_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  drive_reg, drive_next;
    logic                  fail_reg, fail_next;
    logic [7:0]            rx_reg, rx_next;
    logic                  done_w;

    res_t       rq_mem [2];
    logic       rq_wr_reg;
    logic       rq_rd_reg;
    logic [1:0] rq_cnt_reg;
    logic       rq_full;
    logic       fire;
    logic       do_pop;
    res_t       res_w;

    assign rq_full = (rq_cnt_reg == 2'd2);
    assign fire    = q_valid & ~rq_full;
    assign q_pop   = fire;
    assign empty   = (rq_cnt_reg == 2'd0);
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        delay_next = delay_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        done_w     = 1'b0;

        if (fire && q_item.kind == K_TICK && phase_reg != PH_IDLE)
        begin
            if (phase_reg == PH_WA_POLL)
            begin
                if (!q_item.sda)
                begin
                    scl_next = 1'b0;
                    done_w   = 1'b1;
                end
                else if (poll_reg >= cfg.ack_timeout)
                begin
                    // timeout: flag it and run a stop condition
                    fail_next  = 1'b1;
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    delay_next = sat_delay(cfg.start_stop_delay);
                    phase_next = PH_SP_A;
                end
                else
                begin
                    poll_next = poll_reg + 8'd1;
                end
            end
            else if (delay_reg > DELAY_BITS'(1))
            begin
                delay_next = delay_reg - DELAY_BITS'(1);
            end
            else
            begin
                case (phase_reg)
                    PH_ST_A:
                    begin
                        sda_next   = 1'b0;
                        delay_next = sat_delay(cfg.start_stop_delay);
                        phase_next = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        scl_next = 1'b0;
                        done_w   = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        scl_next   = 1'b1;
                        delay_next = sat_delay(cfg.start_stop_delay);
                        phase_next = PH_SP_B;
                    end
                    PH_SP_B:
                    begin
                        sda_next   = 1'b1;
                        delay_next = sat_delay(cfg.start_stop_delay);
                        phase_next = PH_SP_C;
                    end
                    PH_WR_LOW:
                    begin
                        scl_next   = 1'b1;
                        delay_next = sat_delay(cfg.bit_delay);
                        phase_next = PH_WR_HIGH;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_next   = 1'b0;
                        delay_next = sat_delay(cfg.bit_delay);
                        phase_next = PH_WR_TAIL;
                    end
                    PH_WR_TAIL:
                    begin
                        bits_next  = bits_reg + 4'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bits_next >= 4'd8)
                        begin
                            done_w = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_reg[6];
                            delay_next = sat_delay(cfg.bit_delay);
                            phase_next = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        scl_next   = 1'b1;
                        delay_next = sat_delay(cfg.sample_delay);
                        phase_next = PH_RD_HIGH;
                    end
                    PH_RD_HIGH:
                    begin
                        // sample SDA at the end of the SCL-high phase
                        shift_next = {shift_reg[6:0], q_item.sda};
                        bits_next  = bits_reg + 4'd1;
                        scl_next   = 1'b0;
                        if (bits_next >= 4'd8)
                        begin
                            drive_next = 1'b1;
                            sda_next   = ~ackc_reg;
                            delay_next = sat_delay(cfg.bit_delay);
                            phase_next = PH_AK_LOW;
                        end
                        else
                        begin
                            delay_next = sat_delay(cfg.sample_delay);
                            phase_next = PH_RD_LOW;
                        end
                    end
                    PH_AK_LOW:
                    begin
                        scl_next   = 1'b1;
                        delay_next = sat_delay(cfg.bit_delay);
                        phase_next = PH_AK_HIGH;
                    end
                    PH_AK_HIGH:
                    begin
                        scl_next = 1'b0;
                        rx_next  = shift_reg;
                        done_w   = 1'b1;
                    end
                    PH_WA_LOW:
                    begin
                        scl_next   = 1'b1;
                        delay_next = sat_delay(cfg.sample_delay);
                        phase_next = PH_WA_HIGH;
                    end
                    PH_WA_HIGH:
                    begin
                        poll_next  = 8'd0;
                        delay_next = '0;
                        phase_next = PH_WA_POLL;
                    end
                    default:
                    begin
                        done_w = 1'b1;
                    end
                endcase
            end
            if (done_w)
                phase_next = PH_IDLE;
        end
        else if (fire && q_item.kind == K_CMD && phase_reg == PH_IDLE)
        begin
            case (q_item.op)
                OP_START:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    delay_next = sat_delay(cfg.start_stop_delay);
                    phase_next = PH_ST_A;
                end
                OP_STOP:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    delay_next = sat_delay(cfg.start_stop_delay);
                    phase_next = PH_SP_A;
                end
                OP_WRITE:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    bits_next  = 4'd0;
                    shift_next = q_item.data;
                    sda_next   = q_item.data[7];
                    delay_next = sat_delay(cfg.bit_delay);
                    phase_next = PH_WR_LOW;
                end
                OP_READ:
                begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b0;
                    bits_next  = 4'd0;
                    shift_next = 8'd0;
                    ackc_next  = q_item.ack;
                    delay_next = sat_delay(cfg.sample_delay);
                    phase_next = PH_RD_LOW;
                end
                default:
                begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                    fail_next  = 1'b0;
                    poll_next  = 8'd0;
                    delay_next = sat_delay(cfg.sample_delay);
                    phase_next = PH_WA_LOW;
                end
            endcase
        end
    end

    always_comb
    begin
        res_w.scl   = scl_next;
        res_w.sda   = sda_next;
        res_w.drive = drive_next;
        res_w.busy  = (phase_next != PH_IDLE);
        res_w.done  = done_w;
        res_w.rx    = rx_next;
        res_w.fail  = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bits_reg  <= 4'd0;
            delay_reg <= '0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            ackc_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drive_reg <= 1'b1;
            fail_reg  <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            delay_reg <= delay_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            fail_reg  <= fail_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rq_mem[rq_wr_reg] <= res_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (fire)
                rq_wr_reg <= ~rq_wr_reg;
            if (do_pop)
                rq_rd_reg <= ~rq_rd_reg;
            case ({fire, do_pop})
                2'b10:   rq_cnt_reg <= rq_cnt_reg + 2'd1;
                2'b01:   rq_cnt_reg <= rq_cnt_reg - 2'd1;
                default: rq_cnt_reg <= rq_cnt_reg;
            endcase
        end
    end

    assign scl_level  = rq_mem[rq_rd_reg].scl;
    assign sda_level  = rq_mem[rq_rd_reg].sda;
    assign sda_drive  = rq_mem[rq_rd_reg].drive;
    assign busy_res   = rq_mem[rq_rd_reg].busy;
    assign done_res   = rq_mem[rq_rd_reg].done;
    assign rx_byte    = rq_mem[rq_rd_reg].rx;
    assign ack_failed = rq_mem[rq_rd_reg].fail;

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg <= 2'd2)
        else $error("result queue count out of range");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done_w |=> phase_reg == PH_IDLE)
        else $error("command finished but engine not idle");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && rq_full |=> $stable(phase_reg) && $stable(delay_reg))
        else $error("engine advanced while result queue full");

endmodule
